>>> design/robc_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// robc_pkg
// shared types and constants for the reorder buffer commit unit
// ---------------------------------------------------------------------------
package robc_pkg;

    // field widths of the command and result ports
    localparam int OP_W        = 2;
    localparam int REG_W       = 7;
    localparam int SLOT_W      = 4;
    localparam int OCC_W       = 5;

    // default buffer depth
    localparam int DEPTH_DEF   = 16;

    // register number that is never released
    localparam logic [REG_W-1:0] RESERVED_REG = 7'd99;

    // command codes
    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_MARK  = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

endpackage : robc_pkg
`default_nettype wire

>>> design/robc_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// robc_ram
// simple dual port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module robc_ram
    import robc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule : robc_ram
`default_nettype wire

>>> design/reorder_buffer_commit_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// reorder_buffer_commit_unit
// circular reorder buffer: allocate at tail, mark executed, in-order commit
// ---------------------------------------------------------------------------
// a command is captured in the command register, and its result strobe (done)
//   is then registered in the result register behind it
// throughput: one command per clock, busy is always low; the head entry is
//   prefetched from the entry ram every cycle so a tick never waits on it
// reset: rst_n clears pointers, count and executed bits at once; no clearing
//   pass, the entry ram is only read at a held head entry
// the receiver cannot stall: every result is shown for exactly one cycle
module reorder_buffer_commit_unit
    import robc_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // command side
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [OP_W-1:0]   operation,
    input  wire logic [REG_W-1:0]  old_reg,
    input  wire logic              old_reg_valid,
    input  wire logic [SLOT_W-1:0] slot_index,
    input  wire logic              head_reg_locked,
    // result side
    output logic                   done,
    output logic [SLOT_W-1:0]      alloc_slot,
    output logic                   overflow,
    output logic                   committed,
    output logic                   free_valid,
    output logic [REG_W-1:0]       free_reg,
    output logic                   full_res,
    output logic                   empty_res,
    output logic [OCC_W-1:0]       occupancy
);

    localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // pointer width
    localparam int CW  = $clog2(DEPTH + 1);                 // count width
    localparam int EW  = REG_W + 1;                         // ram entry width

    // -----------------------------------------------------------------------
    // command register: every transfer is captured, no back pressure
    // -----------------------------------------------------------------------
    logic              cmd_valid_reg;
    logic [OP_W-1:0]   op_reg;
    logic [REG_W-1:0]  old_reg_reg;
    logic              old_reg_valid_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              locked_reg;

    logic              cmd_take;

    assign busy     = 1'b0;
    assign cmd_take = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            op_reg            <= operation;
            old_reg_reg       <= old_reg;
            old_reg_valid_reg <= old_reg_valid;
            slot_reg          <= slot_index;
            locked_reg        <= head_reg_locked;
        end
    end

    // -----------------------------------------------------------------------
    // buffer state
    // -----------------------------------------------------------------------
    logic [PW-1:0]    head_reg, head_next;
    logic [PW-1:0]    tail_reg, tail_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [DEPTH-1:0] exec_reg, exec_next;

    // head entry prefetch with write bypass
    logic             byp_hit_reg, byp_hit_next;
    logic [EW-1:0]    byp_data_reg;
    logic [EW-1:0]    ram_rdata;
    logic [EW-1:0]    head_entry;

    // entry ram write port
    logic             ram_we;
    logic [EW-1:0]    ram_wdata;

    // result next values
    logic              alloc_ok;
    logic [SLOT_W-1:0] alloc_slot_next;
    logic              overflow_next;
    logic              committed_next;
    logic              free_valid_next;
    logic [REG_W-1:0]  free_reg_next;

    logic [31:0]       slot_ext;
    logic [PW-1:0]     slot_idx;
    logic              slot_in_range;
    logic [31:0]       tail_ext;
    logic [31:0]       count_ext;
    logic              buf_full;
    logic              buf_empty;
    logic [REG_W-1:0]  head_old_reg;
    logic              head_old_valid;

    assign head_entry     = byp_hit_reg ? byp_data_reg : ram_rdata;
    assign head_old_reg   = head_entry[REG_W-1:0];
    assign head_old_valid = head_entry[REG_W];

    assign slot_ext       = 32'(slot_reg);
    assign slot_idx       = slot_ext[PW-1:0];
    assign slot_in_range  = slot_ext < 32'(DEPTH);
    assign tail_ext       = 32'(tail_reg);
    assign buf_full       = count_reg == CW'(DEPTH);
    assign buf_empty      = count_reg == '0;

    assign ram_wdata      = {old_reg_valid_reg, old_reg_reg};

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        exec_next       = exec_reg;
        alloc_ok        = 1'b0;
        alloc_slot_next = '0;
        overflow_next   = 1'b0;
        committed_next  = 1'b0;
        free_valid_next = 1'b0;
        free_reg_next   = '0;

        if (cmd_valid_reg)
        begin
            unique case (op_reg)
                OP_ALLOC:
                begin
                    if (buf_full)
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        alloc_ok            = 1'b1;
                        exec_next[tail_reg] = 1'b0;
                        alloc_slot_next     = tail_ext[SLOT_W-1:0];
                        tail_next           = (tail_reg == PW'(DEPTH - 1)) ? '0
                                                                          : tail_reg + PW'(1);
                        count_next          = count_reg + CW'(1);
                    end
                end
                OP_MARK:
                begin
                    if (slot_in_range)
                    begin
                        exec_next[slot_idx] = 1'b1;
                    end
                end
                OP_TICK:
                begin
                    // a held head entry that has executed retires
                    if (!buf_empty && exec_reg[head_reg])
                    begin
                        committed_next = 1'b1;
                        if (head_old_valid && head_old_reg != RESERVED_REG && !locked_reg)
                        begin
                            free_valid_next = 1'b1;
                            free_reg_next   = head_old_reg;
                        end
                        head_next  = (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + PW'(1);
                        count_next = count_reg - CW'(1);
                    end
                end
                default:
                begin
                    // unused code: status only
                end
            endcase
        end
    end

    assign ram_we       = alloc_ok;
    // the ram reads the next head; a write to that slot this cycle is bypassed
    assign byp_hit_next = ram_we && (tail_reg == head_next);

    assign count_ext    = 32'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            exec_reg    <= '0;
            byp_hit_reg <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            exec_reg    <= exec_next;
            byp_hit_reg <= byp_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= ram_wdata;
    end

    // old register and its valid flag, one entry per slot
    robc_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (ram_wdata),
        .raddr (head_next),
        .rdata (ram_rdata)
    );

    // -----------------------------------------------------------------------
    // result register: one strobe per command
    // -----------------------------------------------------------------------
    logic              done_reg;
    logic [SLOT_W-1:0] alloc_slot_reg;
    logic              overflow_reg;
    logic              committed_reg;
    logic              free_valid_reg;
    logic [REG_W-1:0]  free_reg_reg;
    logic              full_reg;
    logic              empty_reg;
    logic [OCC_W-1:0]  occupancy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid_reg)
        begin
            alloc_slot_reg <= alloc_slot_next;
            overflow_reg   <= overflow_next;
            committed_reg  <= committed_next;
            free_valid_reg <= free_valid_next;
            free_reg_reg   <= free_reg_next;
            full_reg       <= count_next == CW'(DEPTH);
            empty_reg      <= count_next == '0;
            occupancy_reg  <= count_ext[OCC_W-1:0];
        end
    end

    assign done       = done_reg;
    assign alloc_slot = alloc_slot_reg;
    assign overflow   = overflow_reg;
    assign committed  = committed_reg;
    assign free_valid = free_valid_reg;
    assign free_reg   = free_reg_reg;
    assign full_res   = full_reg;
    assign empty_res  = empty_reg;
    assign occupancy  = occupancy_reg;

endmodule : reorder_buffer_commit_unit
`default_nettype wire

>>> design/robc_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// robc_checker
// port level checks for the reorder buffer commit unit
// ---------------------------------------------------------------------------
module robc_checker
    import robc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic             busy,
    input  wire logic             done,
    input  wire logic             overflow,
    input  wire logic             committed,
    input  wire logic             free_valid,
    input  wire logic [REG_W-1:0] free_reg,
    input  wire logic             full_res,
    input  wire logic             empty_res
);

    // every transfer is followed by its result strobe
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("result strobe missing two cycles after transfer");

    // a refused allocate leaves the buffer full
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && overflow) |-> (full_res && !committed))
        else $error("overflow without a full buffer");

    // a register is only released by a retirement, never the reserved one
    a_free_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && free_valid) |-> (committed && free_reg != RESERVED_REG))
        else $error("register released without commit or reserved");

    // full and empty never together
    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(full_res && empty_res))
        else $error("buffer reported full and empty");

endmodule : robc_checker

bind reorder_buffer_commit_unit robc_checker u_robc_checker (.*);
`default_nettype wire
